// ===== hw/rtl/vvs_pkg.sv =====
`timescale 1ns / 1ps

package vvs_pkg;

   // Fixed-point constants, Q16.16
   localparam logic [16:0] ONE_Q16   = 17'h10000;
   localparam logic [17:0] THREE_Q16 = 18'h30000;
   localparam logic [15:0] HALF_Q16  = 16'h8000;

   // Configuration register indexes
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_Z     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FALL_OFF  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STRENGTH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE      = 3'd7;

   // Volume shapes, codes above noise act like noise
   localparam logic [2:0] SHAPE_SPHERE = 3'd0;
   localparam logic [2:0] SHAPE_BOX    = 3'd1;
   localparam logic [2:0] SHAPE_PLANE  = 3'd2;
   localparam logic [2:0] SHAPE_ZEBRA  = 3'd3;
   localparam logic [2:0] SHAPE_NOISE  = 3'd4;

   // Blend modes, codes above invert act like invert
   localparam logic [2:0] BLEND_OVERRIDE = 3'd0;
   localparam logic [2:0] BLEND_ADD      = 3'd1;
   localparam logic [2:0] BLEND_SUB      = 3'd2;
   localparam logic [2:0] BLEND_MULTIPLY = 3'd3;
   localparam logic [2:0] BLEND_INVERT   = 3'd4;

   // Pipeline depths of the iterative units
   localparam int unsigned SQRT_STEPS = 32;
   localparam int unsigned DIV_STEPS  = 16;

   // Register reset values
   localparam logic [63:0] ROW_X_RESET    = 64'd1024;
   localparam logic [63:0] ROW_Y_RESET    = 64'd67108864;
   localparam logic [63:0] ROW_Z_RESET    = 64'd1099511627776;
   localparam logic [17:0] FALL_OFF_RESET = 18'd32768;
   localparam logic [18:0] STRENGTH_RESET = 19'd65536;

   // Falloff control carried alongside the divider
   typedef struct packed {
      logic        direct;
      logic [16:0] s_direct;
      logic        use_div;
      logic [16:0] t_fixed;
   } fctl_type;

endpackage

// ===== hw/rtl/vertex_volume_selection.sv =====
`timescale 1ns / 1ps

// Vertex volume selection: one vertex enters per clock while the pipeline is
// not frozen, and its new selection appears on the result port from the output
// register; the pipeline is 60 registers deep. Every stage is registered
// and the whole pipeline advances together; it freezes only while a finished
// result sits in the output register with rsp_stall high. Depth is set by the
// 32-stage square root (one root bit per stage), the 16-stage falloff divider
// (one quotient bit per stage) and twelve further stages for input capture,
// the matrix, the squares, falloff setup, smoothstep, blend and the output
// register. Configuration writes are always taken (csr_ready is tied high)
// and must only happen while no vertex is in flight.
module vertex_volume_selection (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [31:0]              req_pos_x,
   input  logic signed [31:0]              req_pos_y,
   input  logic signed [31:0]              req_pos_z,
   input  logic signed [23:0]              req_sel_in,
   input  logic                            req_is_last,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [23:0]              rsp_sel_out,
   output logic                            rsp_last_out,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [vvs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [63:0]                     csr_data
);
   import vvs_pkg::*;

   // Configuration registers
   logic [63:0]        row_x_ff, row_y_ff, row_z_ff;
   logic [17:0]        fall_off_ff;
   logic signed [18:0] strength_ff;
   logic signed [20:0] phase_ff;
   logic signed [17:0] threshold_ff;
   logic [6:0]         mode_ff;
   logic [2:0]         shape;
   logic [2:0]         blend;
   logic               clamp_en;

   assign csr_ready = 1'b1;
   assign shape     = mode_ff[2:0];
   assign blend     = mode_ff[5:3];
   assign clamp_en  = mode_ff[6];

   always_ff @(posedge clock) begin
      if (reset) begin
         row_x_ff     <= ROW_X_RESET;
         row_y_ff     <= ROW_Y_RESET;
         row_z_ff     <= ROW_Z_RESET;
         fall_off_ff  <= FALL_OFF_RESET;
         strength_ff  <= $signed(STRENGTH_RESET);
         phase_ff     <= '0;
         threshold_ff <= '0;
         mode_ff      <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ROW_X:     row_x_ff     <= csr_data;
            CSR_ROW_Y:     row_y_ff     <= csr_data;
            CSR_ROW_Z:     row_z_ff     <= csr_data;
            CSR_FALL_OFF:  fall_off_ff  <= csr_data[17:0];
            CSR_STRENGTH:  strength_ff  <= $signed(csr_data[18:0]);
            CSR_PHASE:     phase_ff     <= $signed(csr_data[20:0]);
            CSR_THRESHOLD: threshold_ff <= $signed(csr_data[17:0]);
            CSR_MODE:      mode_ff      <= csr_data[6:0];
            default:       mode_ff      <= mode_ff;
         endcase
      end
   end

   // Global advance: move unless a held result is stalled
   logic out_valid_ff;
   logic en;

   assign en        = !out_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // Stage 0: input capture
   logic               s0_valid_ff;
   logic signed [31:0] s0_pos_ff [3];
   logic signed [23:0] s0_sel_ff;
   logic               s0_last_ff;

   always_ff @(posedge clock) begin
      if (reset) s0_valid_ff <= 1'b0;
      else if (en) s0_valid_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_pos_ff[0] <= req_pos_x;
         s0_pos_ff[1] <= req_pos_y;
         s0_pos_ff[2] <= req_pos_z;
         s0_sel_ff    <= req_sel_in;
         s0_last_ff   <= req_is_last;
      end
   end

   // Stage 1: matrix products, one multiplier per term
   logic [63:0]        rows [3];
   logic               s1_valid_ff;
   logic signed [47:0] s1_prod_ff [3][3];
   logic signed [23:0] s1_sel_ff;
   logic               s1_last_ff;

   assign rows[0] = row_x_ff;
   assign rows[1] = row_y_ff;
   assign rows[2] = row_z_ff;

   for (genvar r = 0; r < 3; r++) begin : g_row
      for (genvar j = 0; j < 3; j++) begin : g_term
         logic signed [15:0] coeff;
         assign coeff = $signed(rows[r][j*16 +: 16]);
         always_ff @(posedge clock) begin
            if (en) s1_prod_ff[r][j] <= coeff * s0_pos_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (en) s1_valid_ff <= s0_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_sel_ff  <= s0_sel_ff;
         s1_last_ff <= s0_last_ff;
      end
   end

   // Stage 2: row sums, floor shift by ten, saturate to 32 bits
   logic               s2_valid_ff;
   logic signed [31:0] s2_vol_ff [3];
   logic signed [23:0] s2_sel_ff;
   logic               s2_last_ff;

   for (genvar r = 0; r < 3; r++) begin : g_sum
      logic signed [31:0] off;
      logic signed [49:0] acc;
      logic signed [49:0] sh;
      logic signed [31:0] vol_in;
      assign off = $signed({rows[r][63:48], 16'h0000});
      assign acc = 50'(s1_prod_ff[r][0]) + 50'(s1_prod_ff[r][1])
                 + 50'(s1_prod_ff[r][2]) + 50'(off);
      assign sh  = acc >>> 10;
      always_comb begin
         if (sh > 50'sh7FFFFFFF) vol_in = 32'sh7FFFFFFF;
         else if (sh < -50'sh80000000) vol_in = -32'sh80000000;
         else vol_in = sh[31:0];
      end
      always_ff @(posedge clock) begin
         if (en) s2_vol_ff[r] <= vol_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else if (en) s2_valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_sel_ff  <= s1_sel_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   // Stage 3: squares for the sphere, distance for the other shapes
   logic [31:0]        av [3];
   logic [31:0]        max_xy;
   logic [31:0]        max_abs;
   logic [16:0]        zr;
   logic signed [17:0] zdiff;
   logic signed [17:0] zabs;
   logic signed [17:0] zd;
   logic signed [33:0] xalt_in;
   logic               s3_valid_ff;
   logic [63:0]        s3_sq_ff [3];
   logic signed [33:0] s3_xalt_ff;
   logic signed [23:0] s3_sel_ff;
   logic               s3_last_ff;

   for (genvar r = 0; r < 3; r++) begin : g_sq
      assign av[r] = s2_vol_ff[r][31] ? 32'(-s2_vol_ff[r]) : 32'(s2_vol_ff[r]);
      always_ff @(posedge clock) begin
         if (en) s3_sq_ff[r] <= 64'(av[r]) * 64'(av[r]);
      end
   end

   assign max_xy  = (av[0] > av[1]) ? av[0] : av[1];
   assign max_abs = (max_xy > av[2]) ? max_xy : av[2];
   assign zr      = 17'(s2_vol_ff[1] + 32'(phase_ff));
   assign zdiff   = $signed({1'b0, zr}) - 18'sd65536;
   assign zabs    = zdiff[17] ? -zdiff : zdiff;
   assign zd      = 18'sd65536 - zabs;

   always_comb begin
      unique case (shape)
         SHAPE_BOX:   xalt_in = $signed({2'b00, max_abs}) + 34'(phase_ff);
         SHAPE_PLANE: xalt_in = 34'(s2_vol_ff[1]);
         SHAPE_ZEBRA: xalt_in = 34'(zd);
         default:     xalt_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else if (en) s3_valid_ff <= s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_xalt_ff <= xalt_in;
         s3_sel_ff  <= s2_sel_ff;
         s3_last_ff <= s2_last_ff;
      end
   end

   // Stage 4: sum of squares
   logic               s4_valid_ff;
   logic [63:0]        s4_sum_ff;
   logic signed [33:0] s4_xalt_ff;
   logic signed [23:0] s4_sel_ff;
   logic               s4_last_ff;

   always_ff @(posedge clock) begin
      if (reset) s4_valid_ff <= 1'b0;
      else if (en) s4_valid_ff <= s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_sum_ff  <= s3_sq_ff[0] + s3_sq_ff[1] + s3_sq_ff[2];
         s4_xalt_ff <= s3_xalt_ff;
         s4_sel_ff  <= s3_sel_ff;
         s4_last_ff <= s3_last_ff;
      end
   end

   // Square root: one root bit per stage
   logic               rt_valid_ff [SQRT_STEPS];
   logic [63:0]        rt_rem_ff   [SQRT_STEPS];
   logic [63:0]        rt_root_ff  [SQRT_STEPS];
   logic signed [33:0] rt_xalt_ff  [SQRT_STEPS];
   logic signed [23:0] rt_sel_ff   [SQRT_STEPS];
   logic               rt_last_ff  [SQRT_STEPS];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
      logic               v_src;
      logic [63:0]        rem_src;
      logic [63:0]        root_src;
      logic signed [33:0] xalt_src;
      logic signed [23:0] sel_src;
      logic               last_src;
      logic [63:0]        trial;

      if (k == 0) begin : g_first
         assign v_src    = s4_valid_ff;
         assign rem_src  = s4_sum_ff;
         assign root_src = '0;
         assign xalt_src = s4_xalt_ff;
         assign sel_src  = s4_sel_ff;
         assign last_src = s4_last_ff;
      end else begin : g_next
         assign v_src    = rt_valid_ff[k-1];
         assign rem_src  = rt_rem_ff[k-1];
         assign root_src = rt_root_ff[k-1];
         assign xalt_src = rt_xalt_ff[k-1];
         assign sel_src  = rt_sel_ff[k-1];
         assign last_src = rt_last_ff[k-1];
      end

      assign trial = root_src + BIT;

      always_ff @(posedge clock) begin
         if (reset) rt_valid_ff[k] <= 1'b0;
         else if (en) rt_valid_ff[k] <= v_src;
      end

      // Subtract the trial value when it fits, else shift the root down
      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_src >= trial) begin
               rt_rem_ff[k]  <= rem_src - trial;
               rt_root_ff[k] <= (root_src >> 1) + BIT;
            end else begin
               rt_rem_ff[k]  <= rem_src;
               rt_root_ff[k] <= root_src >> 1;
            end
            rt_xalt_ff[k] <= xalt_src;
            rt_sel_ff[k]  <= sel_src;
            rt_last_ff[k] <= last_src;
         end
      end
   end

   // Falloff setup: pick distance and edge, classify the smoothstep input
   logic signed [33:0] fx_x;
   logic signed [21:0] fx_a;
   logic signed [34:0] fx_num;
   logic signed [34:0] fx_f;
   fctl_type           fx_ctl_in;
   logic               fx_valid_ff;
   logic [18:0]        fx_num_ff;
   fctl_type           fx_ctl_ff;
   logic signed [23:0] fx_sel_ff;
   logic               fx_last_ff;

   assign fx_x   = (shape == SHAPE_SPHERE)
                   ? $signed({1'b0, rt_root_ff[SQRT_STEPS-1][32:0]})
                   : rt_xalt_ff[SQRT_STEPS-1];
   assign fx_f   = $signed({17'd0, fall_off_ff});
   assign fx_num = 35'(fx_a) - 35'(fx_x);

   always_comb begin
      unique case (shape)
         SHAPE_PLANE: fx_a = $signed({4'd0, fall_off_ff});
         SHAPE_ZEBRA: fx_a = 22'(threshold_ff) + $signed({6'd0, HALF_Q16})
                             + $signed({4'd0, fall_off_ff});
         default:     fx_a = $signed({5'd0, ONE_Q16}) + $signed({4'd0, fall_off_ff});
      endcase
   end

   always_comb begin
      fx_ctl_in          = '0;
      if (shape >= SHAPE_NOISE) begin
         fx_ctl_in.direct   = 1'b1;
         fx_ctl_in.s_direct = ONE_Q16;
      end else if (fall_off_ff == '0) begin
         // zero falloff: hard step at the edge
         fx_ctl_in.direct   = 1'b1;
         fx_ctl_in.s_direct = (fx_num >= 0) ? ONE_Q16 : '0;
      end else if (fx_num <= 0) begin
         fx_ctl_in.t_fixed  = '0;
      end else if (fx_num >= fx_f) begin
         fx_ctl_in.t_fixed  = ONE_Q16;
      end else begin
         fx_ctl_in.use_div  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) fx_valid_ff <= 1'b0;
      else if (en) fx_valid_ff <= rt_valid_ff[SQRT_STEPS-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fx_num_ff  <= fx_num[18:0];
         fx_ctl_ff  <= fx_ctl_in;
         fx_sel_ff  <= rt_sel_ff[SQRT_STEPS-1];
         fx_last_ff <= rt_last_ff[SQRT_STEPS-1];
      end
   end

   // Divider: t = num * 2^16 / falloff, one quotient bit per stage
   logic               dv_valid_ff [DIV_STEPS];
   logic [18:0]        dv_rem_ff   [DIV_STEPS];
   logic [15:0]        dv_quo_ff   [DIV_STEPS];
   fctl_type           dv_ctl_ff   [DIV_STEPS];
   logic signed [23:0] dv_sel_ff   [DIV_STEPS];
   logic               dv_last_ff  [DIV_STEPS];

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      logic               v_src;
      logic [18:0]        rem_src;
      logic [15:0]        quo_src;
      fctl_type           ctl_src;
      logic signed [23:0] sel_src;
      logic               last_src;
      logic [19:0]        r2;

      if (k == 0) begin : g_first
         assign v_src    = fx_valid_ff;
         assign rem_src  = fx_num_ff;
         assign quo_src  = '0;
         assign ctl_src  = fx_ctl_ff;
         assign sel_src  = fx_sel_ff;
         assign last_src = fx_last_ff;
      end else begin : g_next
         assign v_src    = dv_valid_ff[k-1];
         assign rem_src  = dv_rem_ff[k-1];
         assign quo_src  = dv_quo_ff[k-1];
         assign ctl_src  = dv_ctl_ff[k-1];
         assign sel_src  = dv_sel_ff[k-1];
         assign last_src = dv_last_ff[k-1];
      end

      assign r2 = {rem_src, 1'b0};

      always_ff @(posedge clock) begin
         if (reset) dv_valid_ff[k] <= 1'b0;
         else if (en) dv_valid_ff[k] <= v_src;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (r2 >= 20'(fall_off_ff)) begin
               dv_rem_ff[k] <= 19'(r2 - 20'(fall_off_ff));
               dv_quo_ff[k] <= {quo_src[14:0], 1'b1};
            end else begin
               dv_rem_ff[k] <= r2[18:0];
               dv_quo_ff[k] <= {quo_src[14:0], 1'b0};
            end
            dv_ctl_ff[k]  <= ctl_src;
            dv_sel_ff[k]  <= sel_src;
            dv_last_ff[k] <= last_src;
         end
      end
   end

   // Smoothstep first product: t squared
   logic [16:0]        t1_t;
   logic [33:0]        t1_sq;
   logic               t1_valid_ff;
   logic [16:0]        t1_t_ff;
   logic [16:0]        t1_tt_ff;
   fctl_type           t1_ctl_ff;
   logic signed [23:0] t1_sel_ff;
   logic               t1_last_ff;

   assign t1_t  = dv_ctl_ff[DIV_STEPS-1].use_div
                  ? {1'b0, dv_quo_ff[DIV_STEPS-1]}
                  : dv_ctl_ff[DIV_STEPS-1].t_fixed;
   assign t1_sq = 34'(t1_t) * 34'(t1_t);

   always_ff @(posedge clock) begin
      if (reset) t1_valid_ff <= 1'b0;
      else if (en) t1_valid_ff <= dv_valid_ff[DIV_STEPS-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_t_ff    <= t1_t;
         t1_tt_ff   <= t1_sq[32:16];
         t1_ctl_ff  <= dv_ctl_ff[DIV_STEPS-1];
         t1_sel_ff  <= dv_sel_ff[DIV_STEPS-1];
         t1_last_ff <= dv_last_ff[DIV_STEPS-1];
      end
   end

   // Smoothstep second product: t^2 * (3 - 2t)
   logic [17:0]        t2_fac;
   logic [34:0]        t2_prod;
   logic               t2_valid_ff;
   logic [16:0]        t2_s_ff;
   logic signed [23:0] t2_sel_ff;
   logic               t2_last_ff;

   assign t2_fac  = THREE_Q16 - {t1_t_ff, 1'b0};
   assign t2_prod = 35'(t1_tt_ff) * 35'(t2_fac);

   always_ff @(posedge clock) begin
      if (reset) t2_valid_ff <= 1'b0;
      else if (en) t2_valid_ff <= t1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t2_s_ff    <= t1_ctl_ff.direct ? t1_ctl_ff.s_direct : t2_prod[32:16];
         t2_sel_ff  <= t1_sel_ff;
         t2_last_ff <= t1_last_ff;
      end
   end

   // Blend stage 1: products with strength and selection
   logic signed [17:0] b1_s;
   logic signed [25:0] b1_inv;
   logic               b1_valid_ff;
   logic signed [36:0] b1_sst_ff;
   logic signed [42:0] b1_selst_ff;
   logic signed [41:0] b1_sels_ff;
   logic signed [43:0] b1_invp_ff;
   logic signed [17:0] b1_s_ff;
   logic signed [23:0] b1_sel_ff;
   logic               b1_last_ff;

   assign b1_s   = $signed({1'b0, t2_s_ff});
   assign b1_inv = 26'sd65536 - 26'(t2_sel_ff);

   always_ff @(posedge clock) begin
      if (reset) b1_valid_ff <= 1'b0;
      else if (en) b1_valid_ff <= t2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b1_sst_ff   <= b1_s * strength_ff;
         b1_selst_ff <= t2_sel_ff * strength_ff;
         b1_sels_ff  <= t2_sel_ff * b1_s;
         b1_invp_ff  <= b1_s * b1_inv;
         b1_s_ff     <= b1_s;
         b1_sel_ff   <= t2_sel_ff;
         b1_last_ff  <= t2_last_ff;
      end
   end

   // Blend stage 2: scale down, form the multiply-mode difference
   logic signed [41:0] b2_sels_sh;
   logic               b2_valid_ff;
   logic signed [26:0] b2_m_ff;
   logic signed [20:0] b2_sst_ff;
   logic signed [26:0] b2_selst_ff;
   logic signed [27:0] b2_invp_ff;
   logic signed [17:0] b2_s_ff;
   logic signed [23:0] b2_sel_ff;
   logic               b2_last_ff;

   assign b2_sels_sh = b1_sels_ff >>> 16;

   always_ff @(posedge clock) begin
      if (reset) b2_valid_ff <= 1'b0;
      else if (en) b2_valid_ff <= b1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b2_m_ff     <= 27'(b2_sels_sh) - 27'(b1_sel_ff);
         b2_sst_ff   <= 21'(b1_sst_ff >>> 16);
         b2_selst_ff <= 27'(b1_selst_ff >>> 16);
         b2_invp_ff  <= 28'(b1_invp_ff >>> 16);
         b2_s_ff     <= b1_s_ff;
         b2_sel_ff   <= b1_sel_ff;
         b2_last_ff  <= b1_last_ff;
      end
   end

   // Blend stage 3: multiply-mode difference times strength
   logic               b3_valid_ff;
   logic signed [45:0] b3_mst_ff;
   logic signed [20:0] b3_sst_ff;
   logic signed [26:0] b3_selst_ff;
   logic signed [27:0] b3_invp_ff;
   logic signed [17:0] b3_s_ff;
   logic signed [23:0] b3_sel_ff;
   logic               b3_last_ff;

   always_ff @(posedge clock) begin
      if (reset) b3_valid_ff <= 1'b0;
      else if (en) b3_valid_ff <= b2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b3_mst_ff   <= b2_m_ff * strength_ff;
         b3_sst_ff   <= b2_sst_ff;
         b3_selst_ff <= b2_selst_ff;
         b3_invp_ff  <= b2_invp_ff;
         b3_s_ff     <= b2_s_ff;
         b3_sel_ff   <= b2_sel_ff;
         b3_last_ff  <= b2_last_ff;
      end
   end

   // Blend select, optional clamp, saturate into the output register
   logic signed [31:0] bl_res;
   logic signed [31:0] bl_clamped;
   logic signed [23:0] sel_out_in;
   logic signed [23:0] sel_out_ff;
   logic               last_out_ff;

   always_comb begin
      unique case (blend)
         BLEND_OVERRIDE: bl_res = 32'(b3_sst_ff);
         BLEND_ADD:      bl_res = 32'(b3_s_ff) + 32'(b3_selst_ff);
         BLEND_SUB:      bl_res = 32'(b3_sel_ff) - 32'(b3_sst_ff);
         BLEND_MULTIPLY: bl_res = 32'(b3_sel_ff) + 32'(b3_mst_ff >>> 16);
         default:        bl_res = 32'(b3_invp_ff);
      endcase
   end

   always_comb begin
      bl_clamped = bl_res;
      if (clamp_en) begin
         if (bl_res < 0) bl_clamped = '0;
         else if (bl_res > 32'sd65536) bl_clamped = 32'sd65536;
      end
      if (bl_clamped > 32'sd8388607) sel_out_in = 24'sh7FFFFF;
      else if (bl_clamped < -32'sd8388608) sel_out_in = -24'sh800000;
      else sel_out_in = bl_clamped[23:0];
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (en) out_valid_ff <= b3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sel_out_ff  <= sel_out_in;
         last_out_ff <= b3_last_ff;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_sel_out  = sel_out_ff;
   assign rsp_last_out = last_out_ff;

   // Checks on internal arithmetic
   a_root_fits: assert property (@(posedge clock) disable iff (reset)
      rt_valid_ff[SQRT_STEPS-1] |-> rt_root_ff[SQRT_STEPS-1][63:32] == '0)
      else $error("square root exceeds 32 bits");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (dv_valid_ff[DIV_STEPS-1] && dv_ctl_ff[DIV_STEPS-1].use_div)
         |-> dv_rem_ff[DIV_STEPS-1] < 19'(fall_off_ff))
      else $error("divider remainder not below falloff");

   a_falloff_range: assert property (@(posedge clock) disable iff (reset)
      t2_valid_ff |-> t2_s_ff <= ONE_Q16)
      else $error("falloff above one");

   a_clamp_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && clamp_en) |-> (rsp_sel_out >= 0 && rsp_sel_out <= 24'sd65536))
      else $error("clamped result out of range");

endmodule
